// ----- hdl/sed_pkg.sv -----
// Shared types and status codes for the signed Euclidean divider.
`timescale 1ns / 1ps

package sed_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_DIV0 = 2'd1;
	localparam status_t ST_OVF  = 2'd2;

endpackage

// ----- hdl/signed_euclidean_divider.sv -----
// Signed Euclidean divider: radix-2 restoring core under a small sequencer.
`timescale 1ns / 1ps
// The result beat follows the accepting edge through S_DIV, S_FIX and S_FIN;
//   a zero divisor is answered on the cycle right after the accepting edge.
// A new beat is taken only in idle, so the shared subtractor serves one division at a time:
//   one quotient bit per cycle, the remainder fixup, the sign step, then the idle result beat.
// busy is high from a nonzero-divisor accept until the result beat; done is a one-cycle strobe.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and clears done.

module signed_euclidean_divider #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [DATA_WIDTH-1:0] dividend,
	input  logic signed [DATA_WIDTH-1:0] divisor,
	output logic                        done,
	output logic signed [DATA_WIDTH-1:0] quotient,
	output logic        [DATA_WIDTH-2:0] remainder,
	output sed_pkg::status_t            status
);

	import sed_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int CNT_W = $clog2(DATA_WIDTH);

	// sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;	// one quotient bit per cycle
	localparam logic [1:0] S_FIX  = 2'd2;	// Euclidean remainder fixup
	localparam logic [1:0] S_FIN  = 2'd3;	// sign, overflow check, result beat

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;	// partial remainder
	logic [W-1:0]     quo_q;	// dividend magnitude shifting out, quotient shifting in
	logic [W-1:0]     bmag_q;	// divisor magnitude
	logic             aneg_q;
	logic             bneg_q;

	logic                done_q;
	logic [W-1:0]        quot_q;
	logic [W-2:0]        rem_out_q;
	status_t             status_q;

	logic         accept;
	logic [W-1:0] amag_in;
	logic [W-1:0] bmag_in;
	logic [W:0]   shifted;
	logic [W:0]   sub_a;
	logic [W:0]   sub_b;
	logic [W:0]   diff;
	logic         qneg;
	logic [W-1:0] quo_neg;

	assign accept  = start && (state_q == S_IDLE);
	assign amag_in = dividend[W-1] ? (~dividend + 1'b1) : dividend;
	assign bmag_in = divisor[W-1]  ? (~divisor + 1'b1)  : divisor;

	assign shifted = {rem_q, quo_q[W-1]};

	// the one shared subtractor: trial subtract while dividing, |b| - r in fixup
	always_comb begin
		if (state_q == S_FIX) begin
			sub_a = {1'b0, bmag_q};
			sub_b = {1'b0, rem_q};
		end else begin
			sub_a = shifted;
			sub_b = {1'b0, bmag_q};
		end
	end
	assign diff = sub_a - sub_b;

	assign qneg    = (aneg_q != bneg_q) && (quo_q != '0);
	assign quo_neg = ~quo_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (divisor == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_DIV;
							cnt_q   <= CNT_W'(DATA_WIDTH - 1);
						end
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_FIX;
					end
					cnt_q <= cnt_q - 1'b1;
				end
				S_FIX: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					rem_q  <= '0;
					quo_q  <= amag_in;
					bmag_q <= bmag_in;
					aneg_q <= dividend[W-1];
					bneg_q <= divisor[W-1];
					if (divisor == '0) begin
						quot_q    <= '0;
						rem_out_q <= '0;
						status_q  <= ST_DIV0;
					end
				end
			end
			S_DIV: begin
				if (!diff[W]) begin
					rem_q <= diff[W-1:0];
				end else begin
					rem_q <= shifted[W-1:0];
				end
				quo_q <= {quo_q[W-2:0], ~diff[W]};
			end
			S_FIX: begin
				// negative dividend with a remainder: bump magnitude, mirror remainder
				if (aneg_q && (rem_q != '0)) begin
					rem_q <= diff[W-1:0];
					quo_q <= quo_q + 1'b1;
				end
			end
			S_FIN: begin
				// only a positive quotient of 2^(W-1) can overflow
				if (!qneg && quo_q[W-1]) begin
					quot_q    <= '0;
					rem_out_q <= '0;
					status_q  <= ST_OVF;
				end else begin
					quot_q    <= qneg ? quo_neg : quo_q;
					rem_out_q <= rem_q[W-2:0];
					status_q  <= ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign quotient  = quot_q;
	assign remainder = rem_out_q;
	assign status    = status_q;

endmodule

// ----- hdl/sed_checker.sv -----
// Port-level checks for the signed Euclidean divider, bound to the top level.
`timescale 1ns / 1ps

module sed_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic signed [DATA_WIDTH-1:0] dividend,
	input logic signed [DATA_WIDTH-1:0] divisor,
	input logic                         done,
	input logic signed [DATA_WIDTH-1:0] quotient,
	input logic        [DATA_WIDTH-2:0] remainder,
	input sed_pkg::status_t             status
);

	import sed_pkg::*;

	// zero divisor answers on the next beat with zeroed fields
	a_div0: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (divisor == '0) |=>
			done && (status == ST_DIV0) && (quotient == '0) && (remainder == '0))
		else $error("zero divisor not answered");

	// a real division keeps the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (divisor != '0) |=> busy && !done)
		else $error("divide did not go busy");

	// result beat only once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// error beats carry zero fields, and no unused status code appears
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |->
			(quotient == '0) && (remainder == '0) &&
			((status == ST_DIV0) || (status == ST_OVF)))
		else $error("error beat with nonzero fields");

endmodule

bind signed_euclidean_divider sed_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sed_checker (.*);

// ----- tb/sv/tb_signed_euclidean_divider.sv -----
// Self-checking testbench for the signed Euclidean divider: directed table, then random bursts.
`timescale 1ns / 1ps

module tb_signed_euclidean_divider;
	import sed_pkg::*;

	localparam int W = 32;
	localparam int RANDOM_ITEMS = 1900;
	// Longest stretch with no accepted beat on either side before the run is declared hung.
	// The worst correct case is the longest sender gap plus one full division, well under this.
	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_PRINTS = 100;

	localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] S_MAX = ~S_MIN;
	localparam logic [W-2:0] R_TOP = '1;
	// Magnitude of the most negative quotient; one more than the largest positive one.
	localparam logic [W:0] Q_NEG_LIMIT = (W+1)'(1) << (W-1);

	// One result beat: quotient, remainder and status, in port order.
	typedef struct packed {
		logic signed [W-1:0] quo;
		logic [W-2:0] rem;
		status_t st;
	} quot_rem_t;

	// One row of stimulus; typed rows carry their result, open rows go to the predictor.
	typedef struct packed {
		logic signed [W-1:0] a;
		logic signed [W-1:0] b;
		bit typed;
		quot_rem_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [W-1:0] dividend;
	logic signed [W-1:0] divisor;
	logic done;
	logic signed [W-1:0] quotient;
	logic [W-2:0] remainder;
	status_t status;

	quot_rem_t owed_results[$];	// results still due, oldest first
	stim_row_t plan[$];
	int beats_taken;
	int err_count;
	int quiet_cycles;
	// Handoff from the driver to the monitor for the beat now on the input ports.
	bit row_typed;
	quot_rem_t row_result;

	signed_euclidean_divider #(
		.DATA_WIDTH(W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.dividend(dividend),
		.divisor(divisor),
		.done(done),
		.quotient(quotient),
		.remainder(remainder),
		.status(status)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Euclidean division: divide magnitudes, then if the dividend is negative and
	// something is left over, bump the quotient magnitude and flip the remainder so
	// that it lands in 0 .. |b|-1. Zero divisor and a quotient that cannot be
	// represented both give zero fields with their own status.
	function automatic quot_rem_t euclid_divide(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [W-1:0] amag;
		logic [W-1:0] bmag;
		logic [W:0] uq;
		logic [W-1:0] ur;
		logic qneg;
		quot_rem_t res;
		res = '0;
		if (b == 0) begin
			res.st = ST_DIV0;
			return res;
		end
		amag = a[W-1] ? ~a + 1'b1 : a;
		bmag = b[W-1] ? ~b + 1'b1 : b;
		uq = amag / bmag;
		ur = amag % bmag;
		if (a[W-1] && ur != 0) begin
			uq = uq + 1'b1;
			ur = bmag - ur;
		end
		qneg = (a[W-1] != b[W-1]) && uq != 0;
		if (qneg ? (uq > Q_NEG_LIMIT) : (uq > Q_NEG_LIMIT - 1'b1)) begin
			res.st = ST_OVF;
			return res;
		end
		res.quo = qneg ? ~uq[W-1:0] + 1'b1 : uq[W-1:0];
		res.rem = ur[W-2:0];
		res.st = ST_OK;
		return res;
	endfunction

	function automatic stim_row_t typed_row(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b, input logic signed [W-1:0] q,
			input logic [W-2:0] r, input status_t st);
		stim_row_t row;
		row.a = a;
		row.b = b;
		row.typed = 1'b1;
		row.res.quo = q;
		row.res.rem = r;
		row.res.st = st;
		return row;
	endfunction

	function automatic stim_row_t open_row(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		stim_row_t row;
		row = '0;
		row.a = a;
		row.b = b;
		return row;
	endfunction

	// Operand mix: plain random words, small values around zero (zero divisors
	// included), the corner values, powers of two give or take one, and short words.
	function automatic logic signed [W-1:0] rand_operand();
		logic signed [W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5: v = $signed($urandom_range(0, 80)) - 40;
			6: begin
				case ($urandom_range(0, 4))
					0: v = S_MIN;
					1: v = S_MAX;
					2: v = '0;
					3: v = -1;
					default: v = 1;
				endcase
			end
			7: begin
				v = 1 << $urandom_range(0, W-1);
				if ($urandom_range(0, 1))
					v = -v;
				v = v + $signed($urandom_range(0, 2)) - 1;
			end
			default: begin
				v = $urandom >> $urandom_range(1, W-1);
				if ($urandom_range(0, 1))
					v = ~v;
			end
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Present one beat at a falling edge and hold it until the block takes it.
	// Returns on the falling edge right after the accepting rising edge, with start
	// still high, so the caller either follows with the next beat or drops start.
	task automatic send_beat(input stim_row_t row);
		int seen;
		seen = beats_taken;
		row_typed = row.typed;
		row_result = row.res;
		start <= 1'b1;
		dividend <= row.a;
		divisor <= row.b;
		do
			@(negedge clk);
		while (beats_taken == seen);
	endtask

	// Sender pause until every owed result has come back.
	task automatic drain_owed();
		start <= 1'b0;
		while (owed_results.size() != 0)
			@(negedge clk);
	endtask

	// Monitor: sampled on the rising edge, so it sees the values that the edge acts on.
	// A result beat is retired before a new input beat is booked; both may share an edge.
	always @(posedge clk) begin : monitor
		quot_rem_t got;
		quot_rem_t want;
		if (arst_n) begin
			if (done) begin
				got = {quotient, remainder, status};
				if (owed_results.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing owed: q=%0d r=%0d st=%0d",
						got.quo, got.rem, got.st));
				end else begin
					want = owed_results.pop_front();
					if (got.quo !== want.quo)
						report_mismatch($sformatf("quotient %0d, want %0d", got.quo, want.quo));
					if (got.rem !== want.rem)
						report_mismatch($sformatf("remainder %0d, want %0d", got.rem, want.rem));
					if (got.st !== want.st)
						report_mismatch($sformatf("status %0d, want %0d", got.st, want.st));
				end
			end
			if (start && !busy) begin
				owed_results.push_back(row_typed ? row_result : euclid_divide(dividend, divisor));
				beats_taken++;
			end
		end
	end

	// Watchdog: any accepted beat, in or out, resets the count.
	always @(posedge clk) begin
		if (arst_n && (done || (start && !busy))) begin
			quiet_cycles <= 0;
		end else if (arst_n && quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else if (arst_n) begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int sent;
		int burst;
		int gap;
		bit drained_mid;
		stim_row_t row;
		arst_n = 1'b0;
		start = 1'b0;
		dividend = '0;
		divisor = '0;
		row_typed = 1'b0;
		row_result = '0;
		beats_taken = 0;
		err_count = 0;
		quiet_cycles = 0;
		drained_mid = 1'b0;

		// Directed table. Zero divisor, the lone overflow case, the four sign
		// combinations, zero dividend over a negative divisor, and the corner values.
		plan.push_back(typed_row('0, '0, '0, '0, ST_DIV0));
		plan.push_back(typed_row(S_MAX, '0, '0, '0, ST_DIV0));
		plan.push_back(typed_row(S_MIN, '0, '0, '0, ST_DIV0));
		plan.push_back(typed_row(-1, '0, '0, '0, ST_DIV0));
		plan.push_back(typed_row(S_MIN, -1, '0, '0, ST_OVF));
		plan.push_back(typed_row(S_MIN, 1, S_MIN, '0, ST_OK));
		plan.push_back(typed_row(S_MAX, 1, S_MAX, '0, ST_OK));
		plan.push_back(typed_row(S_MAX, -1, -S_MAX, '0, ST_OK));
		plan.push_back(typed_row('0, -5, '0, '0, ST_OK));
		plan.push_back(typed_row('0, S_MIN, '0, '0, ST_OK));
		plan.push_back(typed_row(7, 2, 3, 1, ST_OK));
		plan.push_back(typed_row(-7, 2, -4, 1, ST_OK));
		plan.push_back(typed_row(7, -2, -3, 1, ST_OK));
		plan.push_back(typed_row(-7, -2, 4, 1, ST_OK));
		plan.push_back(typed_row(-1, 1, -1, '0, ST_OK));
		plan.push_back(typed_row(-1, -1, 1, '0, ST_OK));
		plan.push_back(typed_row(S_MIN, S_MIN, 1, '0, ST_OK));
		plan.push_back(typed_row(S_MAX, S_MAX, 1, '0, ST_OK));
		plan.push_back(typed_row(S_MAX, S_MIN, '0, R_TOP, ST_OK));
		plan.push_back(typed_row(-1, S_MIN, 1, R_TOP, ST_OK));
		plan.push_back(open_row(S_MIN, S_MAX));
		plan.push_back(open_row(S_MIN + 1, S_MIN));
		plan.push_back(open_row(S_MIN, 2));
		plan.push_back(open_row(123456789, -1000));
		plan.push_back(open_row(-987654321, 77777));

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats go back to back.
		foreach (plan[i])
			send_beat(plan[i]);
		drain_owed();
		@(negedge clk);

		// Random part: bursts of back-to-back beats, then a gap that is sometimes
		// zero, sometimes short, sometimes longer than a whole division, so the
		// sender restarts at every point of the block's work. Halfway through the
		// sender stops once and lets every owed result come home.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 48);
			for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
				if ($urandom_range(0, 149) == 0)
					row = open_row(S_MIN, -1);
				else
					row = open_row(rand_operand(), rand_operand());
				send_beat(row);
				sent++;
			end
			if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
				drained_mid = 1'b1;
				drain_owed();
			end else begin
				case ($urandom_range(0, 3))
					0: gap = 0;
					1: gap = $urandom_range(1, 5);
					2: gap = $urandom_range(6, 40);
					default: gap = $urandom_range(30, 90);
				endcase
				if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end

		// Wind down: every result home, then a division's worth of quiet to catch strays.
		drain_owed();
		repeat (W + 8) @(negedge clk);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
